[rtl/core/fdbt_pkg.sv]
// Package for the flash die busy-time tracker.
// Holds request/response payload types, opcode and register codes, and table types.
// No dependencies.
package fdbt_pkg;

  localparam int NUM_DIES  = 64;  // power of two: die index reduces by truncation
  localparam int DIE_W     = (NUM_DIES > 1) ? $clog2(NUM_DIES) : 1;
  localparam int TIME_W    = 64;
  localparam int LAT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_INVALID = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    MODE_TWO_LEVEL   = 2'd0,
    MODE_THREE_LEVEL = 2'd1,
    MODE_FOUR_LEVEL  = 2'd2,
    MODE_UNUSED      = 2'd3
  } cell_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_MODE = 3'd0,
    CFG_LEVEL0    = 3'd1,
    CFG_LEVEL1    = 3'd2,
    CFG_LEVEL2    = 3'd3,
    CFG_LEVEL3    = 3'd4,
    CFG_ERASE     = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RMW  = 1'b1
  } fdbt_state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        die_index;
    logic [TIME_W-1:0] now_time;
    logic [1:0]        page_level;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] done_time;
    logic              bad_request;
  } rsp_t;

  // control from the sequencer to the die table
  typedef struct packed {
    logic              rd_en;
    logic [DIE_W-1:0]  rd_addr;
    logic              wr_en;
    logic [DIE_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;
  } tbl_ctl_t;

endpackage

[rtl/core/fdbt_cfg.sv]
// Configuration registers and latency selection for the busy-time tracker.
// Depends on fdbt_pkg.
module fdbt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fdbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdbt_pkg::CFG_W-1:0]       cfg_data,
  input  logic [1:0]                       kind,
  input  logic [1:0]                       page_level,
  output logic [fdbt_pkg::LAT_W-1:0]       latency
);
  import fdbt_pkg::*;

  logic [1:0]       cell_mode;
  logic [63:0]      level_lat [4];
  logic [LAT_W-1:0] erase_lat;
  logic [1:0]       sel;
  logic [63:0]      pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_mode    <= '0;
      level_lat[0] <= '0;
      level_lat[1] <= '0;
      level_lat[2] <= '0;
      level_lat[3] <= '0;
      erase_lat    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_MODE: cell_mode    <= cfg_data[1:0];
        CFG_LEVEL0:    level_lat[0] <= cfg_data;
        CFG_LEVEL1:    level_lat[1] <= cfg_data;
        CFG_LEVEL2:    level_lat[2] <= cfg_data;
        CFG_LEVEL3:    level_lat[3] <= cfg_data;
        CFG_ERASE:     erase_lat    <= cfg_data[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  // page level to latency slot; the unused mode behaves as two-level cells
  always_comb begin
    unique case (cell_mode)
      MODE_FOUR_LEVEL:  sel = page_level;
      MODE_THREE_LEVEL: sel = (page_level <= 2'd1) ? page_level : 2'd3;
      default:          sel = (page_level == 2'd3) ? 2'd3 : 2'd0;
    endcase
  end

  assign pair = level_lat[sel];

  always_comb begin
    unique case (kind)
      KIND_READ:  latency = pair[LAT_W-1:0];
      KIND_WRITE: latency = pair[63:LAT_W];
      KIND_ERASE: latency = erase_lat;
      default:    latency = '0;
    endcase
  end

endmodule

[rtl/core/fdbt_die_table.sv]
// Per-die free-time table: synchronous RAM with a registered read.
// Valid bits make unwritten entries read as zero after reset. Depends on fdbt_pkg.
module fdbt_die_table (
  input  logic                          clk,
  input  logic                          rst,
  input  fdbt_pkg::tbl_ctl_t            ctl,
  output logic [fdbt_pkg::TIME_W-1:0]   rd_time
);
  import fdbt_pkg::*;

  logic [TIME_W-1:0] mem [NUM_DIES];
  logic [NUM_DIES-1:0] vld;
  logic [TIME_W-1:0] rd_data;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= vld[ctl.rd_addr];
      end
    end
  end

  assign rd_time = rd_vld ? rd_data : '0;

endmodule

[rtl/core/flash_die_busy_time_tracker_top.sv]
// Channel    | handshake            | payload
// request    | req_valid, req_stall | req (kind, die_index, now_time, page_level)
// response   | rsp_valid, rsp_stall | rsp (done_time, bad_request)
// config     | cfg_we               | cfg_index, cfg_data
// A request goes through a table read on accept, then add/compare and write-back.
// One request in flight at a time, set by the die table read-modify-write.
// Sync reset clears all die times through the table's valid bits.
// A held response keeps the add/compare and write-back step waiting; req_stall stays high meanwhile.
// Depends on fdbt_pkg, fdbt_cfg, fdbt_die_table.
module flash_die_busy_time_tracker_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  fdbt_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output fdbt_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [fdbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdbt_pkg::CFG_W-1:0]     cfg_data
);
  import fdbt_pkg::*;

  fdbt_state_t       state, state_next;
  logic              accept;
  logic              finish;
  logic [1:0]        kind_q;
  logic [DIE_W-1:0]  die_q;
  logic [TIME_W-1:0] now_q;
  logic [LAT_W-1:0]  lat_q;
  logic [LAT_W-1:0]  latency;
  logic [TIME_W-1:0] old_time;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] new_time;
  logic              is_bad;
  tbl_ctl_t          ctl;

  fdbt_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (req.kind),
    .page_level (req.page_level),
    .latency    (latency)
  );

  fdbt_die_table u_tbl (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_time (old_time)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign finish    = (state == ST_RMW) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_RMW;
      ST_RMW:  if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.kind;
      die_q  <= req.die_index[DIE_W-1:0];
      now_q  <= req.now_time;
      lat_q  <= latency;
    end
  end

  assign is_bad     = (kind_q == KIND_INVALID);
  assign start_time = (now_q < old_time) ? old_time : now_q;
  assign new_time   = start_time + {{(TIME_W-LAT_W){1'b0}}, lat_q};

  always_comb begin
    ctl.rd_en   = accept;
    ctl.rd_addr = req.die_index[DIE_W-1:0];
    ctl.wr_en   = finish && !is_bad;
    ctl.wr_addr = die_q;
    ctl.wr_data = new_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.done_time   <= is_bad ? '0 : new_time;
      rsp.bad_request <= is_bad;
    end
  end

`ifndef SYNTH
  a_wr_in_rmw: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (state == ST_RMW))
    else $error("table write outside read-modify-write");

  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RMW))
    else $error("accepted request did not enter read-modify-write");

  a_rsp_from_rmw: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_RMW))
    else $error("response raised without a request in flight");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bad_request) |-> (rsp.done_time == '0))
    else $error("bad request carries a nonzero time");
`endif

endmodule
